[sv/nppt_pkg.sv]
package nppt_pkg;

  // Defaults of the top-level parameters
  localparam int SAMPLE_RATE_HZ_DEF = 10000;
  localparam int COS_TABLE_BITS_DEF = 10;

  // pi/2 in Q30, and 2^32 / (4*pi) rounded
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [32:0] INV_4PI_Q32 = 33'sd341782638;

  // Rate divide: magnitude of (omega sum * INV_4PI_Q32) >> 16 stays below 2^45
  localparam int DIV_NUM_W = 45;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_NOMINAL_OMEGA = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_B0      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_B1      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_B2      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_A1      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_A2      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PI_GAIN_NOW   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PI_GAIN_PREV  = 3'd7;

  localparam logic        [30:0] NOMINAL_OMEGA_RST = 31'd24706483;
  localparam logic signed [31:0] NOTCH_B0_RST      = 32'sd1065718824;
  localparam logic signed [31:0] NOTCH_B1_RST      = -32'sd2125386041;
  localparam logic signed [31:0] NOTCH_B2_RST      = 32'sd1065716700;
  localparam logic signed [31:0] NOTCH_A1_RST      = -32'sd2125386041;
  localparam logic signed [31:0] NOTCH_A2_RST      = 32'sd1057693679;
  localparam logic signed [31:0] PI_GAIN_NOW_RST   = 32'sd1061032327;
  localparam logic signed [31:0] PI_GAIN_PREV_RST  = -32'sd1043501603;

  // Operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_MIX,
    MUL_B0X0,
    MUL_B1X1,
    MUL_B2X2,
    MUL_A1Y1,
    MUL_A2Y2,
    MUL_GNY0,
    MUL_GPY1,
    MUL_SUMK,
    MUL_QLL,
    MUL_QHL,
    MUL_QLH,
    MUL_QHH
  } mul_sel_t;

  // Accumulator operation on the registered product
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_RND30,
    ACC_RND29,
    ACC_SHADD
  } acc_op_t;

  // Register update performed in this cycle
  typedef enum logic [3:0] {
    ST_NONE,
    ST_SAMPLE,
    ST_COS,
    ST_X0,
    ST_Y0,
    ST_PI,
    ST_OMEGA,
    ST_SUM,
    ST_DIV_LD,
    ST_COMMIT
  } step_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    step_t    step;
  } dp_cmd_t;

  // Quotient of a nonnegative numerator by a positive divisor, shift and subtract.
  // Evaluated at elaboration only.
  function automatic longint udiv_pos(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // Cosine in Q15 of an angle x in Q30 (0..pi/2), eight-term Taylor series.
  // Evaluated at elaboration only.
  function automatic logic [14:0] cos_q15_of(input longint x);
    longint x2;
    longint term;
    longint sum;
    longint r;
    x2   = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    sum  = 64'sd1 <<< 30;
    for (int n = 1; n <= 7; n++) begin
      term = udiv_pos((term * x2) >>> 30, longint'((2 * n - 1) * (2 * n)));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    r = (sum + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return r[14:0];
  endfunction

endpackage

[sv/nppt_ctrl.sv]
module nppt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output nppt_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_COS,
    S_MIX,
    S_X0,
    S_NB0,
    S_NB1,
    S_NB2,
    S_NA1,
    S_NA2,
    S_NEND,
    S_NRND,
    S_NY,
    S_PG0,
    S_PG1,
    S_PEND,
    S_PRND,
    S_PACC,
    S_OMG,
    S_PSUM,
    S_PHM,
    S_DLD,
    S_QLL,
    S_QHL,
    S_QLH,
    S_QHH,
    S_QSUM,
    S_WAIT
  } state_t;

  state_t                          state_r;
  logic                            out_valid_r;
  logic                            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.mul_sel = nppt_pkg::MUL_MIX;
    cmd.acc_op  = nppt_pkg::ACC_HOLD;
    cmd.step    = nppt_pkg::ST_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = nppt_pkg::ST_SAMPLE;
        end
      end
      S_COS:  cmd.step = nppt_pkg::ST_COS;
      S_MIX:  cmd.mul_sel = nppt_pkg::MUL_MIX;
      S_X0:   cmd.step = nppt_pkg::ST_X0;
      S_NB0:  cmd.mul_sel = nppt_pkg::MUL_B0X0;
      S_NB1: begin
        cmd.mul_sel = nppt_pkg::MUL_B1X1;
        cmd.acc_op  = nppt_pkg::ACC_LOAD;
      end
      S_NB2: begin
        cmd.mul_sel = nppt_pkg::MUL_B2X2;
        cmd.acc_op  = nppt_pkg::ACC_ADD;
      end
      S_NA1: begin
        cmd.mul_sel = nppt_pkg::MUL_A1Y1;
        cmd.acc_op  = nppt_pkg::ACC_ADD;
      end
      S_NA2: begin
        cmd.mul_sel = nppt_pkg::MUL_A2Y2;
        cmd.acc_op  = nppt_pkg::ACC_SUB;
      end
      S_NEND: cmd.acc_op = nppt_pkg::ACC_SUB;
      S_NRND: cmd.acc_op = nppt_pkg::ACC_RND30;
      S_NY:   cmd.step = nppt_pkg::ST_Y0;
      S_PG0:  cmd.mul_sel = nppt_pkg::MUL_GNY0;
      S_PG1: begin
        cmd.mul_sel = nppt_pkg::MUL_GPY1;
        cmd.acc_op  = nppt_pkg::ACC_LOAD;
      end
      S_PEND: cmd.acc_op = nppt_pkg::ACC_ADD;
      S_PRND: cmd.acc_op = nppt_pkg::ACC_RND29;
      S_PACC: cmd.step = nppt_pkg::ST_PI;
      S_OMG:  cmd.step = nppt_pkg::ST_OMEGA;
      S_PSUM: cmd.step = nppt_pkg::ST_SUM;
      S_PHM:  cmd.mul_sel = nppt_pkg::MUL_SUMK;
      S_DLD:  cmd.step = nppt_pkg::ST_DIV_LD;
      S_QLL:  cmd.mul_sel = nppt_pkg::MUL_QLL;
      S_QHL: begin
        cmd.mul_sel = nppt_pkg::MUL_QHL;
        cmd.acc_op  = nppt_pkg::ACC_LOAD;
      end
      S_QLH: begin
        cmd.mul_sel = nppt_pkg::MUL_QLH;
        cmd.acc_op  = nppt_pkg::ACC_SHADD;
      end
      S_QHH: begin
        cmd.mul_sel = nppt_pkg::MUL_QHH;
        cmd.acc_op  = nppt_pkg::ACC_ADD;
      end
      S_QSUM: cmd.acc_op = nppt_pkg::ACC_SHADD;
      S_WAIT: begin
        if (out_free) begin
          cmd.step = nppt_pkg::ST_COMMIT;
        end
      end
      default: cmd.step = nppt_pkg::ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished item, or drop the one just taken
      if (state_r == S_WAIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_COS;
          end
        end
        S_COS:  state_r <= S_MIX;
        S_MIX:  state_r <= S_X0;
        S_X0:   state_r <= S_NB0;
        S_NB0:  state_r <= S_NB1;
        S_NB1:  state_r <= S_NB2;
        S_NB2:  state_r <= S_NA1;
        S_NA1:  state_r <= S_NA2;
        S_NA2:  state_r <= S_NEND;
        S_NEND: state_r <= S_NRND;
        S_NRND: state_r <= S_NY;
        S_NY:   state_r <= S_PG0;
        S_PG0:  state_r <= S_PG1;
        S_PG1:  state_r <= S_PEND;
        S_PEND: state_r <= S_PRND;
        S_PRND: state_r <= S_PACC;
        S_PACC: state_r <= S_OMG;
        S_OMG:  state_r <= S_PSUM;
        S_PSUM: state_r <= S_PHM;
        S_PHM:  state_r <= S_DLD;
        S_DLD:  state_r <= S_QLL;
        S_QLL:  state_r <= S_QHL;
        S_QHL:  state_r <= S_QLH;
        S_QLH:  state_r <= S_QHH;
        S_QHH:  state_r <= S_QSUM;
        S_QSUM: state_r <= S_WAIT;
        S_WAIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/nppt_datapath.sv]
module nppt_datapath #(
  parameter int SAMPLE_RATE_HZ = nppt_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int COS_TABLE_BITS = nppt_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nppt_pkg::dp_cmd_t                   cmd,
  input  logic signed [15:0]                  in_sample_voltage,
  input  logic                                cfg_we,
  input  logic [nppt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [nppt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [31:0]                         out_phase_turns,
  output logic signed [31:0]                  out_omega_est
);

  localparam int TBL_N   = 1 << COS_TABLE_BITS;
  localparam int IDX_W   = COS_TABLE_BITS + 1;
  localparam int NUM_W   = nppt_pkg::DIV_NUM_W;
  localparam int HALF_W  = (NUM_W + 1) / 2;
  localparam int RATE_SH = $clog2(SAMPLE_RATE_HZ);
  // floor(2^(NUM_W+RATE_SH) / rate) + 1 gives the exact quotient for any numerator
  // below 2^NUM_W, and fits in 2*HALF_W bits
  localparam logic [127:0] RECIP_FULL =
    ((128'd1 << (NUM_W + RATE_SH)) / 128'(SAMPLE_RATE_HZ)) + 128'd1;
  localparam logic [HALF_W-1:0] RECIP_LO = RECIP_FULL[HALF_W-1:0];
  localparam logic [HALF_W-1:0] RECIP_HI = RECIP_FULL[2*HALF_W-1:HALF_W];
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] HALF_30 = 64'sd1 <<< 29;
  localparam logic signed [63:0] HALF_29 = 64'sd1 <<< 28;

  typedef logic [14:0] cos_tbl_t [TBL_N+1];

  function automatic cos_tbl_t build_cos_tbl();
    cos_tbl_t t;
    for (int k = 0; k <= TBL_N; k++) begin
      t[k] = nppt_pkg::cos_q15_of((nppt_pkg::HALF_PI_Q30 * longint'(k)) >>> COS_TABLE_BITS);
    end
    return t;
  endfunction

  localparam cos_tbl_t COS_TBL = build_cos_tbl();

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic sub);
    logic [64:0] s;
    if (sub) begin
      s = {a[63], a} - {b[63], b};
    end else begin
      s = {a[63], a} + {b[63], b};
    end
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32_of64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat32_of33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return v[31:0];
  endfunction

  // Configuration
  logic        [30:0] nominal_omega_r;
  logic signed [31:0] b0_r, b1_r, b2_r, a1_r, a2_r, gain_now_r, gain_prev_r;

  // Loop state
  logic signed [31:0] x1_r, x2_r, y1_r, y2_r;
  logic signed [31:0] pi_acc_r, prev_omega_r;
  logic        [31:0] phase_r;

  // Per-item work registers
  logic signed [15:0] sample_r;
  logic        [14:0] cos_rd_r;
  logic               cos_neg_r;
  logic signed [31:0] x0_r, y0_r, omega_r;
  logic signed [32:0] sum_r;
  logic signed [63:0] prod_r, acc_r;
  logic               div_neg_r;
  logic [NUM_W-1:0]   num_r;
  logic        [31:0] out_phase_r;
  logic signed [31:0] out_omega_r;

  logic [COS_TABLE_BITS-1:0] tbl_i;
  logic [IDX_W-1:0]          cos_idx;
  logic signed [15:0]        cosine;
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        mul_full;
  logic signed [63:0]        acc_nxt;
  logic signed [32:0]        pi_sum, omega_sum;
  logic signed [63:0]        prod_mag;
  logic signed [63:0]        quot;
  logic [31:0]               d32;
  logic [31:0]               phase_nxt;

  // Odd quadrants read the table mirrored
  assign tbl_i   = phase_r[29 -: COS_TABLE_BITS];
  assign cos_idx = phase_r[30] ? (IDX_W'(TBL_N) - {1'b0, tbl_i}) : {1'b0, tbl_i};
  assign cosine  = cos_neg_r ? -$signed({1'b0, cos_rd_r}) : $signed({1'b0, cos_rd_r});

  always_comb begin
    mul_a = 33'(sample_r);
    mul_b = 33'(cosine);
    case (cmd.mul_sel)
      nppt_pkg::MUL_MIX: begin
        mul_a = 33'(sample_r);
        mul_b = 33'(cosine);
      end
      nppt_pkg::MUL_B0X0: begin
        mul_a = 33'(b0_r);
        mul_b = 33'(x0_r);
      end
      nppt_pkg::MUL_B1X1: begin
        mul_a = 33'(b1_r);
        mul_b = 33'(x1_r);
      end
      nppt_pkg::MUL_B2X2: begin
        mul_a = 33'(b2_r);
        mul_b = 33'(x2_r);
      end
      nppt_pkg::MUL_A1Y1: begin
        mul_a = 33'(a1_r);
        mul_b = 33'(y1_r);
      end
      nppt_pkg::MUL_A2Y2: begin
        mul_a = 33'(a2_r);
        mul_b = 33'(y2_r);
      end
      nppt_pkg::MUL_GNY0: begin
        mul_a = 33'(gain_now_r);
        mul_b = 33'(y0_r);
      end
      nppt_pkg::MUL_GPY1: begin
        mul_a = 33'(gain_prev_r);
        mul_b = 33'(y1_r);
      end
      nppt_pkg::MUL_SUMK: begin
        mul_a = sum_r;
        mul_b = nppt_pkg::INV_4PI_Q32;
      end
      // partial products of numerator halves and reciprocal halves
      nppt_pkg::MUL_QLL: begin
        mul_a = 33'(num_r[HALF_W-1:0]);
        mul_b = 33'(RECIP_LO);
      end
      nppt_pkg::MUL_QHL: begin
        mul_a = 33'(num_r[NUM_W-1:HALF_W]);
        mul_b = 33'(RECIP_LO);
      end
      nppt_pkg::MUL_QLH: begin
        mul_a = 33'(num_r[HALF_W-1:0]);
        mul_b = 33'(RECIP_HI);
      end
      nppt_pkg::MUL_QHH: begin
        mul_a = 33'(num_r[NUM_W-1:HALF_W]);
        mul_b = 33'(RECIP_HI);
      end
      default: begin
        mul_a = 33'(sample_r);
        mul_b = 33'(cosine);
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    case (cmd.acc_op)
      nppt_pkg::ACC_HOLD:  acc_nxt = acc_r;
      nppt_pkg::ACC_LOAD:  acc_nxt = prod_r;
      nppt_pkg::ACC_ADD:   acc_nxt = sat_add64(acc_r, prod_r, 1'b0);
      nppt_pkg::ACC_SUB:   acc_nxt = sat_add64(acc_r, prod_r, 1'b1);
      nppt_pkg::ACC_RND30: acc_nxt = sat_add64(acc_r, HALF_30, 1'b0);
      nppt_pkg::ACC_RND29: acc_nxt = sat_add64(acc_r, HALF_29, 1'b0);
      nppt_pkg::ACC_SHADD: acc_nxt = (acc_r >>> HALF_W) + prod_r;
      default:             acc_nxt = acc_r;
    endcase
  end

  assign pi_sum    = 33'(pi_acc_r) + 33'(sat32_of64(acc_r >>> 29));
  assign omega_sum = $signed({2'b00, nominal_omega_r}) + 33'(pi_acc_r);

  // Divide by the sample rate on the magnitude; quotient truncates toward zero
  assign prod_mag  = prod_r[63] ? -prod_r : prod_r;
  assign quot      = acc_r >>> (RATE_SH - 1);
  assign d32       = div_neg_r ? -quot[31:0] : quot[31:0];
  assign phase_nxt = phase_r + d32;

  always_ff @(posedge clk) begin
    prod_r <= mul_full[63:0];
    acc_r  <= acc_nxt;
    case (cmd.step)
      nppt_pkg::ST_SAMPLE: sample_r <= in_sample_voltage;
      nppt_pkg::ST_COS: begin
        cos_rd_r  <= COS_TBL[cos_idx];
        cos_neg_r <= phase_r[31] ^ phase_r[30];
      end
      nppt_pkg::ST_X0:    x0_r    <= prod_r[31:0];
      nppt_pkg::ST_Y0:    y0_r    <= sat32_of64(acc_r >>> 30);
      nppt_pkg::ST_OMEGA: omega_r <= sat32_of33(omega_sum);
      nppt_pkg::ST_SUM:   sum_r   <= 33'(omega_r) + 33'(prev_omega_r);
      nppt_pkg::ST_DIV_LD: begin
        div_neg_r <= prod_r[63];
        num_r     <= prod_mag[16 +: NUM_W];
      end
      nppt_pkg::ST_COMMIT: begin
        out_phase_r <= phase_nxt;
        out_omega_r <= omega_r;
      end
      default: begin
      end
    endcase
  end

  // Loop state that survives from item to item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r         <= '0;
      x2_r         <= '0;
      y1_r         <= '0;
      y2_r         <= '0;
      pi_acc_r     <= '0;
      prev_omega_r <= '0;
      phase_r      <= '0;
    end else begin
      if (cmd.step == nppt_pkg::ST_PI) begin
        pi_acc_r <= sat32_of33(pi_sum);
      end
      if (cmd.step == nppt_pkg::ST_COMMIT) begin
        phase_r      <= phase_nxt;
        prev_omega_r <= omega_r;
        x2_r         <= x1_r;
        x1_r         <= x0_r;
        y2_r         <= y1_r;
        y1_r         <= y0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_omega_r <= nppt_pkg::NOMINAL_OMEGA_RST;
      b0_r            <= nppt_pkg::NOTCH_B0_RST;
      b1_r            <= nppt_pkg::NOTCH_B1_RST;
      b2_r            <= nppt_pkg::NOTCH_B2_RST;
      a1_r            <= nppt_pkg::NOTCH_A1_RST;
      a2_r            <= nppt_pkg::NOTCH_A2_RST;
      gain_now_r      <= nppt_pkg::PI_GAIN_NOW_RST;
      gain_prev_r     <= nppt_pkg::PI_GAIN_PREV_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        nppt_pkg::REG_NOMINAL_OMEGA: nominal_omega_r <= cfg_wdata[30:0];
        nppt_pkg::REG_NOTCH_B0:      b0_r            <= cfg_wdata;
        nppt_pkg::REG_NOTCH_B1:      b1_r            <= cfg_wdata;
        nppt_pkg::REG_NOTCH_B2:      b2_r            <= cfg_wdata;
        nppt_pkg::REG_NOTCH_A1:      a1_r            <= cfg_wdata;
        nppt_pkg::REG_NOTCH_A2:      a2_r            <= cfg_wdata;
        nppt_pkg::REG_PI_GAIN_NOW:   gain_now_r      <= cfg_wdata;
        nppt_pkg::REG_PI_GAIN_PREV:  gain_prev_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_phase_turns = out_phase_r;
  assign out_omega_est   = out_omega_r;

endmodule

[sv/notch_pll_phase_tracker.sv]
// Single-phase grid PLL: each voltage sample is mixed with the cosine of the tracked phase,
// notched at twice the grid frequency, and fed to a PI loop whose output trims the nominal
// angular frequency; trapezoidal integration of that frequency advances the phase, which is
// an unsigned fraction of a turn (2^32 = one turn). One result item per input item, in Q16.16
// rad/s for frequency. The block works on one item at a time: each item steps through the
// states of the controller until its result is in the output register, and the
// next item can be taken in the cycle after that. Every product goes through one shared
// 33x33 multiplier with a saturating accumulator; the division of the phase increment by
// SAMPLE_RATE_HZ is a multiply by a precomputed reciprocal, split into four partial
// products on that multiplier. A finished result waits in the output register while the
// next item is accepted; the block only holds at the end of an item if the previous result
// has still not been taken. The cosine table has 2^COS_TABLE_BITS + 1 entries, built at
// elaboration, so no pass is needed after reset.
// Write configuration registers only while the block is idle.
module notch_pll_phase_tracker #(
  parameter int SAMPLE_RATE_HZ = nppt_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int COS_TABLE_BITS = nppt_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_sample_voltage,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_phase_turns,
  output logic signed [31:0]               out_omega_est,
  input  logic                             cfg_we,
  input  logic [nppt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [nppt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  nppt_pkg::dp_cmd_t cmd;

  nppt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  nppt_datapath #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_sample_voltage (in_sample_voltage),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_phase_turns   (out_phase_turns),
    .out_omega_est     (out_omega_est)
  );

endmodule

[tb/notch_pll_phase_tracker_tb.sv]
`timescale 1ns / 100ps

module notch_pll_phase_tracker_tb;
  import nppt_pkg::*;

  localparam int TBL_BITS    = COS_TABLE_BITS_DEF;
  localparam int TBL_N       = 1 << TBL_BITS;
  localparam int SAMPLE_RATE = SAMPLE_RATE_HZ_DEF;
  // 2*pi*1 Hz in Q16.16 rad/s, and 2^32 / SAMPLE_RATE for the tone generator
  localparam int OMEGA_PER_HZ = 411775;
  localparam int TURN_PER_HZ  = 429497;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [31:0] omega;
  } pll_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [15:0]      in_sample_voltage;
  logic                    out_valid;
  logic                    out_stall;
  logic [31:0]             out_phase_turns;
  logic signed [31:0]      out_omega_est;
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  // Tracks the PLL state per accepted item and holds the results still owed.
  class pll_scoreboard;
    int                 cos_q15 [TBL_N+1];
    logic [30:0]        nom_omega;
    logic signed [31:0] b0, b1, b2, a1, a2, k_now, k_prev;
    logic signed [31:0] mix_d1, mix_d2, notch_d1, notch_d2, integ, omega_d1;
    logic [31:0]        phase;
    pll_result_t        expected_q [$];
    int                 errors;
    int                 checked;

    function new();
      int k;
      for (k = 0; k <= TBL_N; k++) begin
        cos_q15[k] = taylor_cos((HALF_PI_Q30 * k) >>> TBL_BITS);
      end
      nom_omega = NOMINAL_OMEGA_RST;
      b0 = NOTCH_B0_RST;
      b1 = NOTCH_B1_RST;
      b2 = NOTCH_B2_RST;
      a1 = NOTCH_A1_RST;
      a2 = NOTCH_A2_RST;
      k_now = PI_GAIN_NOW_RST;
      k_prev = PI_GAIN_PREV_RST;
      mix_d1 = 0;
      mix_d2 = 0;
      notch_d1 = 0;
      notch_d2 = 0;
      integ = 0;
      omega_d1 = 0;
      phase = 0;
      errors = 0;
      checked = 0;
    endfunction

    // Q30 angle in, Q15 cosine out, eight Taylor terms
    function int taylor_cos(longint ang);
      longint sq;
      longint term;
      longint acc;
      longint r;
      int n;
      sq = (ang * ang) >>> 30;
      term = 64'sd1 <<< 30;
      acc = term;
      for (n = 1; n <= 7; n++) begin
        term = ((term * sq) >>> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      r = (acc + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      return int'(r);
    endfunction

    function int cosine_at(logic [31:0] p);
      int idx;
      idx = int'(p[29 -: TBL_BITS]);
      case (p[31:30])
        2'd0: return cos_q15[idx];
        2'd1: return -cos_q15[TBL_N - idx];
        2'd2: return -cos_q15[idx];
        default: return cos_q15[TBL_N - idx];
      endcase
    endfunction

    function longint sat_add64(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // round half up, then arithmetic shift
    function longint round_shift(longint v, int s);
      return sat_add64(v, 64'sd1 <<< (s - 1)) >>> s;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_NOMINAL_OMEGA: nom_omega = d[30:0];
        REG_NOTCH_B0:      b0 = d;
        REG_NOTCH_B1:      b1 = d;
        REG_NOTCH_B2:      b2 = d;
        REG_NOTCH_A1:      a1 = d;
        REG_NOTCH_A2:      a2 = d;
        REG_PI_GAIN_NOW:   k_now = d;
        REG_PI_GAIN_PREV:  k_prev = d;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] v);
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] om;
      longint             acc;
      longint             sum;
      longint             dlt;
      pll_result_t        r;
      x0 = int'(v) * cosine_at(phase);
      acc = longint'(b0) * longint'(x0);
      acc = sat_add64(acc, longint'(b1) * longint'(mix_d1));
      acc = sat_add64(acc, longint'(b2) * longint'(mix_d2));
      acc = sat_add64(acc, -(longint'(a1) * longint'(notch_d1)));
      acc = sat_add64(acc, -(longint'(a2) * longint'(notch_d2)));
      y0 = sat32(round_shift(acc, 30));
      acc = longint'(k_now) * longint'(y0);
      acc = sat_add64(acc, longint'(k_prev) * longint'(notch_d1));
      integ = sat32(longint'(integ) + longint'(sat32(round_shift(acc, 29))));
      om = sat32(longint'(nom_omega) + longint'(integ));
      // trapezoid of this and the previous frequency, scaled to turns per sample
      sum = longint'(om) + longint'(omega_d1);
      dlt = (sum * longint'(INV_4PI_Q32)) / (longint'(SAMPLE_RATE) * 64'sd65536);
      phase = phase + dlt[31:0];
      omega_d1 = om;
      mix_d2 = mix_d1;
      mix_d1 = x0;
      notch_d2 = notch_d1;
      notch_d1 = y0;
      r.phase = phase;
      r.omega = om;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] ph, logic signed [31:0] om);
      pll_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: phase_turns=%0d omega_est=%0d", ph, om);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (ph !== r.phase) begin
        $error("phase_turns: expected %0d, got %0d", r.phase, ph);
        errors++;
      end
      if (om !== r.omega) begin
        $error("omega_est: expected %0d, got %0d", r.omega, om);
        errors++;
      end
      checked++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  pll_scoreboard sb;
  logic [31:0]   setting [8];
  bit            tx_idle_on;
  bit            rx_idle_on;
  int            long_hold;
  int            n_settings;
  int            i;

  notch_pll_phase_tracker #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE),
    .COS_TABLE_BITS(TBL_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_voltage(in_sample_voltage),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_phase_turns(out_phase_turns),
    .out_omega_est(out_omega_est),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("[notch_pll_phase_tracker] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_sample(in_sample_voltage);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_phase_turns, out_omega_est);
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] v);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_voltage <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let the block go idle before touching its registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic program_regs();
    int k;
    for (k = 0; k < 8; k++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_ADDR_W'(k);
      cfg_wdata <= setting[k];
      sb.write_reg(CFG_ADDR_W'(k), setting[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic fill_defaults();
    setting[REG_NOMINAL_OMEGA] = {1'b0, NOMINAL_OMEGA_RST};
    setting[REG_NOTCH_B0]      = NOTCH_B0_RST;
    setting[REG_NOTCH_B1]      = NOTCH_B1_RST;
    setting[REG_NOTCH_B2]      = NOTCH_B2_RST;
    setting[REG_NOTCH_A1]      = NOTCH_A1_RST;
    setting[REG_NOTCH_A2]      = NOTCH_A2_RST;
    setting[REG_PI_GAIN_NOW]   = PI_GAIN_NOW_RST;
    setting[REG_PI_GAIN_PREV]  = PI_GAIN_PREV_RST;
  endtask

  // Mostly a nudge around the tuned value, sometimes anything at all
  function automatic logic [31:0] near(logic signed [31:0] base);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return base + int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  task automatic fill_random();
    if ($urandom_range(0, 3) == 0) begin
      setting[REG_NOMINAL_OMEGA] = $urandom;
    end else begin
      setting[REG_NOMINAL_OMEGA] = $urandom_range(45, 65) * OMEGA_PER_HZ;
    end
    setting[REG_NOTCH_B0]     = near(NOTCH_B0_RST);
    setting[REG_NOTCH_B1]     = near(NOTCH_B1_RST);
    setting[REG_NOTCH_B2]     = near(NOTCH_B2_RST);
    setting[REG_NOTCH_A1]     = near(NOTCH_A1_RST);
    setting[REG_NOTCH_A2]     = near(NOTCH_A2_RST);
    setting[REG_PI_GAIN_NOW]  = near(PI_GAIN_NOW_RST);
    setting[REG_PI_GAIN_PREV] = near(PI_GAIN_PREV_RST);
  endtask

  task automatic fill_all(input logic [31:0] omega_word, input logic [31:0] coef_word);
    int k;
    setting[REG_NOMINAL_OMEGA] = omega_word;
    for (k = 1; k < 8; k++) begin
      setting[k] = coef_word;
    end
  endtask

  // Grid-like sine with noise; now and then a full-scale glitch
  task automatic play_tone(input int n, input int freq_hz, input int amp, input int noise);
    logic [31:0] gen_ph;
    logic [31:0] inc;
    int          s;
    int          k;
    gen_ph = $urandom;
    inc = freq_hz * TURN_PER_HZ + int'($urandom_range(0, 20000)) - 10000;
    for (k = 0; k < n; k++) begin
      s = (amp * sb.cosine_at(gen_ph)) >>> 15;
      s = s + int'($urandom_range(0, 2 * noise)) - noise;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      if ($urandom_range(0, 49) == 0) s = int'($urandom_range(0, 65535)) - 32768;
      send_sample(16'(s));
      gen_ph = gen_ph + inc;
    end
  endtask

  task automatic play_noise(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_sample(16'($urandom));
    end
  endtask

  task automatic play_random_tone(input int n);
    play_tone(n, $urandom_range(45, 65), $urandom_range(500, 32767), $urandom_range(0, 2000));
  endtask

  initial begin
    logic signed [15:0] edge_vals [20];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_voltage = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    long_hold = 0;
    n_settings = 0;
    sb = new();
    edge_vals = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA,
                  16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 16'sd12345,
                  -16'sd12345, 16'sd256, -16'sd256, 16'sh7FFE, 16'sh8001, 16'sd0, 16'sd0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values; the first item integrates half a step from zero frequency
    for (i = 0; i < 20; i++) begin
      send_sample(edge_vals[i]);
    end
    play_tone(50, 60, 20000, 300);
    // hold the receiver while items keep coming so the block backs up
    long_hold = 600;
    play_tone(250, 60, 25000, 500);
    drain();

    // Largest coefficients everywhere; bit 31 of the frequency word is dropped
    fill_all(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    program_regs();
    play_noise(80);
    play_random_tone(20);
    drain();

    // Most negative coefficients, zero nominal frequency
    fill_all(32'h0000_0000, 32'h8000_0000);
    program_regs();
    play_noise(80);
    play_random_tone(20);
    drain();

    for (i = 0; i < 4; i++) begin
      fill_random();
      program_regs();
      play_random_tone(100);
      play_noise(20);
      drain();
    end

    // Open loop: the phase advances at the nominal rate plus the integrator value left from before
    fill_all($urandom, 32'h0000_0000);
    program_regs();
    play_noise(50);
    drain();

    fill_defaults();
    setting[REG_NOMINAL_OMEGA] = $urandom_range(50, 60) * OMEGA_PER_HZ;
    program_regs();
    play_tone(200, 60, 30000, 200);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    play_tone(150, 50, 32767, 0);
    drain();

    $display("checked %0d results across %0d register settings after reset defaults",
             sb.checked, n_settings);
    $display("covered extreme and random coefficients, tones, noise and a long output hold");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[notch_pll_phase_tracker] OK");
    end else begin
      $display("[notch_pll_phase_tracker] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/nppt_pkg.sv
sv/nppt_ctrl.sv
sv/nppt_datapath.sv
sv/notch_pll_phase_tracker.sv
tb/notch_pll_phase_tracker_tb.sv
